/* src/kevt_pkg.sv */
// Shared types, key codes and keymap tables of the key event translator.
`timescale 1ns / 1ps
`default_nettype none
package kevt_pkg;

	localparam int unsigned KEYMAP_ENTRIES = 128;
	localparam int unsigned CODE_W = $clog2(KEYMAP_ENTRIES);

	localparam logic [15:0] EVT_KEY = 16'd1;

	localparam logic [CODE_W-1:0] K_LCTRL  = CODE_W'(29);
	localparam logic [CODE_W-1:0] K_LSHIFT = CODE_W'(42);
	localparam logic [CODE_W-1:0] K_RSHIFT = CODE_W'(54);
	localparam logic [CODE_W-1:0] K_CAPS   = CODE_W'(58);
	localparam logic [CODE_W-1:0] K_RCTRL  = CODE_W'(97);
	localparam logic [CODE_W-1:0] K_HOME   = CODE_W'(102);
	localparam logic [CODE_W-1:0] K_UP     = CODE_W'(103);
	localparam logic [CODE_W-1:0] K_PGUP   = CODE_W'(104);
	localparam logic [CODE_W-1:0] K_LEFT   = CODE_W'(105);
	localparam logic [CODE_W-1:0] K_RIGHT  = CODE_W'(106);
	localparam logic [CODE_W-1:0] K_END    = CODE_W'(107);
	localparam logic [CODE_W-1:0] K_DOWN   = CODE_W'(108);
	localparam logic [CODE_W-1:0] K_PGDN   = CODE_W'(109);
	localparam logic [CODE_W-1:0] K_DEL    = CODE_W'(111);

	localparam logic [1:0] VAL_RELEASE = 2'd0;
	localparam logic [1:0] VAL_PRESS   = 2'd1;

	localparam logic [7:0] ASCII_ESC   = 8'h1B;
	localparam logic [7:0] ASCII_LBRK  = 8'h5B;
	localparam logic [7:0] ASCII_TILDE = 8'h7E;
	localparam logic [7:0] ASCII_LC_A  = 8'h61;
	localparam logic [7:0] ASCII_LC_Z  = 8'h7A;
	localparam logic [7:0] CTRL_BIAS   = 8'h60;

	// Up to four bytes, sent from index 0 up to last_idx.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
	} kevt_cmd_t;

	typedef struct packed {
		logic      hit;
		kevt_cmd_t cmd;
	} kevt_esc_t;

	function automatic kevt_esc_t kevt_escape(input logic [CODE_W-1:0] code);
		kevt_esc_t r;
		r.hit = 1'b1;
		r.cmd.bytes = {ASCII_TILDE, 8'h00, ASCII_LBRK, ASCII_ESC};
		r.cmd.last_idx = 2'd2;
		case (code)
			K_UP:    r.cmd.bytes[2] = 8'h41;
			K_DOWN:  r.cmd.bytes[2] = 8'h42;
			K_RIGHT: r.cmd.bytes[2] = 8'h43;
			K_LEFT:  r.cmd.bytes[2] = 8'h44;
			K_HOME:  r.cmd.bytes[2] = 8'h48;
			K_END:   r.cmd.bytes[2] = 8'h46;
			K_PGUP: begin
				r.cmd.bytes[2] = 8'h35;
				r.cmd.last_idx = 2'd3;
			end
			K_PGDN: begin
				r.cmd.bytes[2] = 8'h36;
				r.cmd.last_idx = 2'd3;
			end
			K_DEL: begin
				r.cmd.bytes[2] = 8'h33;
				r.cmd.last_idx = 2'd3;
			end
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] kevt_map_plain(input logic [CODE_W-1:0] code);
		logic [7:0] b;
		case (code)
			7'd1:  b = 8'h1b; 7'd2:  b = 8'h31; 7'd3:  b = 8'h32; 7'd4:  b = 8'h33;
			7'd5:  b = 8'h34; 7'd6:  b = 8'h35; 7'd7:  b = 8'h36; 7'd8:  b = 8'h37;
			7'd9:  b = 8'h38; 7'd10: b = 8'h39; 7'd11: b = 8'h30; 7'd12: b = 8'h2d;
			7'd13: b = 8'h3d; 7'd14: b = 8'h08; 7'd15: b = 8'h09; 7'd16: b = 8'h71;
			7'd17: b = 8'h77; 7'd18: b = 8'h65; 7'd19: b = 8'h72; 7'd20: b = 8'h74;
			7'd21: b = 8'h79; 7'd22: b = 8'h75; 7'd23: b = 8'h69; 7'd24: b = 8'h6f;
			7'd25: b = 8'h70; 7'd26: b = 8'h5b; 7'd27: b = 8'h5d; 7'd28: b = 8'h0a;
			7'd30: b = 8'h61; 7'd31: b = 8'h73; 7'd32: b = 8'h64; 7'd33: b = 8'h66;
			7'd34: b = 8'h67; 7'd35: b = 8'h68; 7'd36: b = 8'h6a; 7'd37: b = 8'h6b;
			7'd38: b = 8'h6c; 7'd39: b = 8'h3b; 7'd40: b = 8'h27; 7'd41: b = 8'h60;
			7'd43: b = 8'h5c; 7'd44: b = 8'h7a; 7'd45: b = 8'h78; 7'd46: b = 8'h63;
			7'd47: b = 8'h76; 7'd48: b = 8'h62; 7'd49: b = 8'h6e; 7'd50: b = 8'h6d;
			7'd51: b = 8'h2c; 7'd52: b = 8'h2e; 7'd53: b = 8'h2f; 7'd57: b = 8'h20;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] kevt_map_shifted(input logic [CODE_W-1:0] code);
		logic [7:0] b;
		case (code)
			7'd1:  b = 8'h1b; 7'd2:  b = 8'h21; 7'd3:  b = 8'h40; 7'd4:  b = 8'h23;
			7'd5:  b = 8'h24; 7'd6:  b = 8'h25; 7'd7:  b = 8'h5e; 7'd8:  b = 8'h26;
			7'd9:  b = 8'h2a; 7'd10: b = 8'h28; 7'd11: b = 8'h29; 7'd12: b = 8'h5f;
			7'd13: b = 8'h2b; 7'd14: b = 8'h08; 7'd15: b = 8'h09; 7'd16: b = 8'h51;
			7'd17: b = 8'h57; 7'd18: b = 8'h45; 7'd19: b = 8'h52; 7'd20: b = 8'h54;
			7'd21: b = 8'h59; 7'd22: b = 8'h55; 7'd23: b = 8'h49; 7'd24: b = 8'h4f;
			7'd25: b = 8'h50; 7'd26: b = 8'h7b; 7'd27: b = 8'h7d; 7'd28: b = 8'h0a;
			7'd30: b = 8'h41; 7'd31: b = 8'h53; 7'd32: b = 8'h44; 7'd33: b = 8'h46;
			7'd34: b = 8'h47; 7'd35: b = 8'h48; 7'd36: b = 8'h4a; 7'd37: b = 8'h4b;
			7'd38: b = 8'h4c; 7'd39: b = 8'h3a; 7'd40: b = 8'h22; 7'd41: b = 8'h7e;
			7'd43: b = 8'h7c; 7'd44: b = 8'h5a; 7'd45: b = 8'h58; 7'd46: b = 8'h43;
			7'd47: b = 8'h56; 7'd48: b = 8'h42; 7'd49: b = 8'h4e; 7'd50: b = 8'h4d;
			7'd51: b = 8'h3c; 7'd52: b = 8'h3e; 7'd53: b = 8'h3f; 7'd57: b = 8'h20;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

/* src/kevt_in_if.sv */
// Channel that carries input events into the translator.
`timescale 1ns / 1ps
`default_nettype none
interface kevt_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] event_type;
	logic [15:0] key_code;
	logic [1:0]  key_value;

	modport source (output valid, event_type, key_code, key_value, input ready);
	modport sink (input valid, event_type, key_code, key_value, output ready);
endinterface
`default_nettype wire

/* src/kevt_out_if.sv */
// Channel that carries translated character bytes out of the translator.
`timescale 1ns / 1ps
`default_nettype none
interface kevt_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       last_byte;

	modport source (output valid, char_byte, last_byte, input ready);
	modport sink (input valid, char_byte, last_byte, output ready);
endinterface
`default_nettype wire

/* src/kevt_front.sv */
// Front end: accepts events, tracks modifiers and builds byte commands.
`timescale 1ns / 1ps
`default_nettype none
module kevt_front
	import kevt_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	kevt_in_if.sink        evt,
	input  wire logic      full,
	output logic           push,
	output kevt_cmd_t      push_cmd
);

	logic              shift_q, ctrl_q, caps_q;
	logic              accept, is_key, is_shift, is_ctrl, is_caps, is_mod;
	logic [CODE_W-1:0] code;
	logic [7:0]        plain, shifted, ch;
	logic              is_letter, use_shift;
	kevt_esc_t         esc;

	assign evt.ready = !full;
	assign accept    = evt.valid && evt.ready;
	assign code      = evt.key_code[CODE_W-1:0];
	assign is_key    = (evt.event_type == EVT_KEY) && (evt.key_code[15:CODE_W] == '0);
	assign is_shift  = (code == K_LSHIFT) || (code == K_RSHIFT);
	assign is_ctrl   = (code == K_LCTRL) || (code == K_RCTRL);
	assign is_caps   = (code == K_CAPS);
	assign is_mod    = is_shift || is_ctrl || is_caps;

	assign esc       = kevt_escape(code);
	assign plain     = kevt_map_plain(code);
	assign shifted   = kevt_map_shifted(code);
	assign is_letter = (plain >= ASCII_LC_A) && (plain <= ASCII_LC_Z);
	assign use_shift = shift_q ^ (caps_q && is_letter);
	assign ch        = use_shift ? shifted : plain;

	always_comb begin
		push_cmd.bytes    = '0;
		push_cmd.last_idx = 2'd0;
		push              = 1'b0;
		if (accept && is_key && !is_mod && evt.key_value != VAL_RELEASE) begin
			if (esc.hit) begin
				push_cmd = esc.cmd;
				push     = 1'b1;
			end else if (ctrl_q) begin
				push_cmd.bytes[0] = plain - CTRL_BIAS;
				push              = is_letter;
			end else begin
				push_cmd.bytes[0] = ch;
				push              = (ch != 8'h00);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 1'b0;
			ctrl_q  <= 1'b0;
			caps_q  <= 1'b0;
		end else if (accept && is_key) begin
			if (is_shift) begin
				shift_q <= (evt.key_value != VAL_RELEASE);
			end
			if (is_ctrl) begin
				ctrl_q <= (evt.key_value != VAL_RELEASE);
			end
			if (is_caps && evt.key_value == VAL_PRESS) begin
				caps_q <= !caps_q;
			end
		end
	end

endmodule
`default_nettype wire

/* src/kevt_queue.sv */
// Small command queue between the front end and the byte sender.
`timescale 1ns / 1ps
`default_nettype none
module kevt_queue
	import kevt_pkg::*;
#(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire kevt_cmd_t  push_cmd,
	output logic            full,
	input  wire logic       pop,
	output kevt_cmd_t       head,
	output logic            empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	kevt_cmd_t          mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* src/kevt_back.sv */
// Back end: sends the bytes of each queued command through an output register.
`timescale 1ns / 1ps
`default_nettype none
module kevt_back
	import kevt_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire kevt_cmd_t head,
	input  wire logic      empty,
	output logic           pop,
	kevt_out_if.source     chr
);

	kevt_cmd_t  cur_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic       ovalid_q;
	logic [7:0] obyte_q;
	logic       olast_q;
	logic       advance;

	assign advance       = !ovalid_q || chr.ready;
	assign pop           = advance && !busy_q && !empty;
	assign chr.valid     = ovalid_q;
	assign chr.char_byte = obyte_q;
	assign chr.last_byte = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			busy_q   <= 1'b0;
		end else if (advance) begin
			if (busy_q) begin
				ovalid_q <= 1'b1;
				busy_q   <= (idx_q != cur_q.last_idx);
			end else if (!empty) begin
				ovalid_q <= 1'b1;
				busy_q   <= (head.last_idx != 2'd0);
			end else begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (busy_q) begin
				obyte_q <= cur_q.bytes[idx_q];
				olast_q <= (idx_q == cur_q.last_idx);
				idx_q   <= idx_q + 1'b1;
			end else if (!empty) begin
				obyte_q <= head.bytes[0];
				olast_q <= (head.last_idx == 2'd0);
				cur_q   <= head;
				idx_q   <= 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

/* src/key_event_to_ascii_translator.sv */
// Top level of the key event to ASCII translator.
//
// Events come in on the evt channel (event_type, key_code, key_value) and
// translated bytes leave on the chr channel (char_byte, last_byte). A
// transfer on evt is taken in every cycle while the command queue has room.
// Modifier keys only update the shift, ctrl and caps lock flags.
// A pressed ordinary key yields at most one byte, a cursor or editing key
// an escape sequence of three or four bytes, and last_byte marks the final byte.
// The first byte is registered in the command queue, then in the output
// register, before it is valid. The output sends one byte a cycle while the
// receiver is ready, and an event that yields bytes has one to four of them.
// When the receiver stalls, the output register holds its byte, the queue
// fills and evt.ready falls; the front keeps no work of its own waiting.
// Reset clears the modifier flags, empties the queue and drops chr.valid.
`timescale 1ns / 1ps
`default_nettype none
module key_event_to_ascii_translator
	import kevt_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	kevt_in_if.sink    evt,
	kevt_out_if.source chr
);

	logic      push, full, pop, empty;
	kevt_cmd_t push_cmd, head;

	kevt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt      (evt),
		.full     (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	kevt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	kevt_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.chr    (chr)
	);

endmodule
`default_nettype wire
